/* hw/rtl/c8sff_pkg.sv */
// Shared constants, types and the CRC-8 byte update for the CRC-8 sliding frame finder.
package c8sff_pkg;

   // Default number of payload bytes in one frame (one CRC byte follows).
   localparam int PAYLOAD_BYTES_DEF = 31;

   // CRC-8, reflected polynomial 0x31 (0x8C after reflection), initial value 0xFF.
   localparam logic [7:0] CRC_INIT      = 8'hFF;
   localparam logic [7:0] CRC_POLY_REFL = 8'h8C;

   // Result kinds.
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_ERROR   = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CRC,
      ST_CHECK,
      ST_EMIT
   } state_type;

   // One byte step of the CRC, LSB first; the argument is the CRC already xored with the byte.
   function automatic logic [7:0] crc8_byte(input logic [7:0] value);
      logic [7:0] crc;
      crc = value;
      for (int b = 0; b < 8; b++) begin
         if (crc[0]) begin
            crc = (crc >> 1) ^ CRC_POLY_REFL;
         end else begin
            crc = crc >> 1;
         end
      end
      return crc;
   endfunction

endpackage

/* hw/rtl/crc8_sliding_frame_finder_top.sv */
// Top level of the CRC-8 sliding frame finder: window memory, CRC walk and result register.
//
// The block takes received serial bytes, one per input beat, into a window held in a
// single-port-write, single-port-read memory of PAYLOAD_BYTES + 1 entries, organized as a
// circular buffer with a head pointer and a fill count. While the window is not yet full a
// byte is taken at once and gives no result. The byte that completes a frame starts a CRC walk:
// the payload bytes are read from the memory one per cycle (the memory read port sets this
// pace) and folded into a CRC-8 (reflected polynomial 0x31, initial value 0xFF, no final xor),
// and the result is compared against the CRC byte in a separate check state.
// On a match the payload is read back and sent out as PAYLOAD_BYTES result beats, one per
// cycle when the receiver does not stall, with last_byte set on the final one, and the window
// is emptied. On a mismatch the error counter is incremented, one error beat is sent (kind = 1,
// payload_byte = 0, last_byte = 1) and only the oldest byte is dropped, so the search for a
// frame boundary moves on by one byte. Every beat carries the running error count. A byte
// that completes a window holds off further bytes until its check, and on a match the
// read-back, is done. The result beat sits in an output register, so the next byte is taken
// while the last beat still waits to be collected. The window memory needs no clearing
// after reset: the fill count keeps it from ever being read at an entry that was not written.
module crc8_sliding_frame_finder_top
   import c8sff_pkg::*;
#(
   parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_kind,
   output logic [7:0]  rsp_payload_byte,
   output logic        rsp_last_byte,
   output logic [31:0] rsp_crc_error_total
);

   // Window size and derived widths.
   localparam int FRAME_BYTES = PAYLOAD_BYTES + 1;
   localparam int AW          = $clog2(FRAME_BYTES);
   localparam int CW          = $clog2(PAYLOAD_BYTES);

   localparam logic [AW-1:0] LAST_ADDR  = AW'(FRAME_BYTES - 1);
   localparam logic [AW-1:0] FULL_FILL  = AW'(PAYLOAD_BYTES);
   localparam logic [CW-1:0] LAST_COUNT = CW'(PAYLOAD_BYTES - 1);
   localparam logic [AW:0]   FRAME_WIDE = (AW + 1)'(FRAME_BYTES);

   // Window memory: written on an accepted beat, read through the registered rd_data_ff.
   logic [7:0]    window_mem [FRAME_BYTES];
   logic          mem_we;
   logic [AW-1:0] mem_waddr;
   logic [7:0]    rd_data_ff;

   // Control and datapath registers.
   state_type     state_ff, state_in;
   logic [AW-1:0] head_ff, head_in;
   logic [AW-1:0] fill_ff, fill_in;
   logic [AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0] count_ff, count_in;
   logic [7:0]    crc_ff, crc_in;
   logic [7:0]    crc_byte_ff, crc_byte_in;
   logic [31:0]   err_count_ff, err_count_in;

   // Output register.
   logic          rsp_valid_ff, rsp_valid_in;
   logic          rsp_kind_ff, rsp_kind_in;
   logic [7:0]    rsp_payload_byte_ff, rsp_payload_byte_in;
   logic          rsp_last_byte_ff, rsp_last_byte_in;
   logic [31:0]   rsp_total_ff, rsp_total_in;

   logic          out_free;
   logic          out_load;
   logic [AW:0]   waddr_sum;
   logic [AW-1:0] rd_ptr_next;
   logic [AW-1:0] head_next;

   // The output register can take a new beat when it is empty or its beat leaves now.
   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Write address is head + fill, wrapped once around the circular window.
   assign waddr_sum = {1'b0, head_ff} + {1'b0, fill_ff};
   assign mem_waddr = (waddr_sum >= FRAME_WIDE) ? AW'(waddr_sum - FRAME_WIDE)
                                                : waddr_sum[AW-1:0];

   assign rd_ptr_next = (rd_ptr_ff == LAST_ADDR) ? '0 : rd_ptr_ff + 1'b1;
   assign head_next   = (head_ff == LAST_ADDR) ? '0 : head_ff + 1'b1;

   always_comb begin
      state_in            = state_ff;
      head_in             = head_ff;
      fill_in             = fill_ff;
      rd_ptr_in           = rd_ptr_ff;
      count_in            = count_ff;
      crc_in              = crc_ff;
      crc_byte_in         = crc_byte_ff;
      err_count_in        = err_count_ff;
      mem_we              = 1'b0;
      out_load            = 1'b0;
      rsp_kind_in         = rsp_kind_ff;
      rsp_payload_byte_in = rsp_payload_byte_ff;
      rsp_last_byte_in    = rsp_last_byte_ff;
      rsp_total_in        = rsp_total_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               mem_we = 1'b1;
               if (fill_ff == FULL_FILL) begin
                  // This byte is the CRC byte of a full frame: start the walk at the head.
                  rd_ptr_in   = head_ff;
                  count_in    = '0;
                  crc_in      = CRC_INIT;
                  crc_byte_in = req_rx_byte;
                  state_in    = ST_CRC;
               end else begin
                  fill_in = fill_ff + 1'b1;
               end
            end
         end

         ST_CRC: begin
            // rd_data_ff holds the window byte at rd_ptr_ff.
            crc_in    = crc8_byte(crc_ff ^ rd_data_ff);
            rd_ptr_in = rd_ptr_next;
            count_in  = count_ff + 1'b1;
            if (count_ff == LAST_COUNT) begin
               count_in = '0;
               state_in = ST_CHECK;
            end
         end

         ST_CHECK: begin
            if (crc_ff == crc_byte_ff) begin
               rd_ptr_in = head_ff;
               count_in  = '0;
               state_in  = ST_EMIT;
            end else if (out_free) begin
               // Mismatch: drop the oldest byte, the window keeps the other PAYLOAD_BYTES.
               err_count_in        = err_count_ff + 1'b1;
               out_load            = 1'b1;
               rsp_kind_in         = KIND_ERROR;
               rsp_payload_byte_in = '0;
               rsp_last_byte_in    = 1'b1;
               rsp_total_in        = err_count_ff + 1'b1;
               head_in             = head_next;
               state_in            = ST_IDLE;
            end
         end

         ST_EMIT: begin
            if (out_free) begin
               out_load            = 1'b1;
               rsp_kind_in         = KIND_PAYLOAD;
               rsp_payload_byte_in = rd_data_ff;
               rsp_last_byte_in    = (count_ff == LAST_COUNT);
               rsp_total_in        = err_count_ff;
               rd_ptr_in           = rd_ptr_next;
               count_in            = count_ff + 1'b1;
               if (count_ff == LAST_COUNT) begin
                  // The whole frame, CRC byte included, leaves the window.
                  count_in = '0;
                  fill_in  = '0;
                  state_in = ST_IDLE;
               end
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = out_load ? 1'b1 : (rsp_valid_ff && rsp_stall);

   // Memory: the read address is the next pointer, so rd_data_ff always matches rd_ptr_ff.
   always_ff @(posedge clock) begin
      if (mem_we) begin
         window_mem[mem_waddr] <= req_rx_byte;
      end
      rd_data_ff <= window_mem[rd_ptr_in];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= '0;
         fill_ff      <= '0;
         count_ff     <= '0;
         err_count_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         head_ff      <= head_in;
         fill_ff      <= fill_in;
         count_ff     <= count_in;
         err_count_ff <= err_count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rd_ptr_ff           <= rd_ptr_in;
      crc_ff              <= crc_in;
      crc_byte_ff         <= crc_byte_in;
      rsp_kind_ff         <= rsp_kind_in;
      rsp_payload_byte_ff <= rsp_payload_byte_in;
      rsp_last_byte_ff    <= rsp_last_byte_in;
      rsp_total_ff        <= rsp_total_in;
   end

   assign req_stall           = (state_ff != ST_IDLE);
   assign rsp_valid           = rsp_valid_ff;
   assign rsp_kind            = rsp_kind_ff;
   assign rsp_payload_byte    = rsp_payload_byte_ff;
   assign rsp_last_byte       = rsp_last_byte_ff;
   assign rsp_crc_error_total = rsp_total_ff;

endmodule

/* test/crc8_sliding_frame_finder_checker.sv */
// Frame CRC helper package and the scoreboard that checks the frame finder's result beats.
`timescale 1ns / 100ps

package c8sff_tb_pkg;
   import c8sff_pkg::*;

   // CRC-8, reflected 0x31, start value 0xFF, over the first count bytes of a byte list.
   function automatic logic [7:0] frame_crc8(input logic [7:0] bytes [$], input int count);
      logic [7:0] acc;
      acc = CRC_INIT;
      for (int i = 0; i < count; i++) begin
         acc = acc ^ bytes[i];
         for (int b = 0; b < 8; b++) begin
            acc = acc[0] ? ((acc >> 1) ^ CRC_POLY_REFL) : (acc >> 1);
         end
      end
      return acc;
   endfunction

endpackage

module crc8_sliding_frame_finder_checker
   import c8sff_pkg::*;
   import c8sff_tb_pkg::*;
#(
   parameter int PAYLOAD_LEN = PAYLOAD_BYTES_DEF
) (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   input  logic        req_stall,
   input  logic [7:0]  req_rx_byte,

   input  logic        rsp_valid,
   input  logic        rsp_stall,
   input  logic        rsp_kind,
   input  logic [7:0]  rsp_payload_byte,
   input  logic        rsp_last_byte,
   input  logic [31:0] rsp_crc_error_total,

   output int          mismatch_count,
   output int          beats_pending,
   output int          bytes_taken,
   output int          frames_found,
   output int          crc_misses,
   output int          beats_checked
);

   typedef struct packed {
      logic        kind;
      logic [7:0]  data;
      logic        last;
      logic [31:0] err_total;
   } finder_beat_type;

   logic [7:0]      window_q [$];
   logic [31:0]     crc_miss_total;
   finder_beat_type beats_due [$];

   // Every mismatch prints one line and is counted.
   task automatic report_mismatch(input string what);
      $display("%0t ns: beat %0d: %s", $time, beats_checked, what);
      mismatch_count++;
   endtask

   // Window bookkeeping for one received byte, pushing the beats it should cause.
   task automatic predict_byte(input logic [7:0] rx);
      finder_beat_type beat;
      window_q.push_back(rx);
      bytes_taken++;
      if (window_q.size() < PAYLOAD_LEN + 1) begin
         return;
      end
      if (frame_crc8(window_q, PAYLOAD_LEN) == window_q[PAYLOAD_LEN]) begin
         for (int i = 0; i < PAYLOAD_LEN; i++) begin
            beat.kind      = KIND_PAYLOAD;
            beat.data      = window_q[i];
            beat.last      = (i == PAYLOAD_LEN - 1);
            beat.err_total = crc_miss_total;
            beats_due.push_back(beat);
         end
         window_q.delete();
         frames_found++;
      end else begin
         // Only the oldest byte leaves, so the next byte triggers another check.
         crc_miss_total = crc_miss_total + 32'd1;
         void'(window_q.pop_front());
         beat = '{KIND_ERROR, 8'h00, 1'b1, crc_miss_total};
         beats_due.push_back(beat);
         crc_misses++;
      end
   endtask

   task automatic check_beat();
      finder_beat_type want;
      if (beats_due.size() == 0) begin
         report_mismatch($sformatf("result beat with nothing expected (kind %0b byte %02h)",
                                   rsp_kind, rsp_payload_byte));
         beats_checked++;
         return;
      end
      want = beats_due.pop_front();
      if (rsp_kind !== want.kind) begin
         report_mismatch($sformatf("kind %0b, expected %0b", rsp_kind, want.kind));
      end
      if (rsp_payload_byte !== want.data) begin
         report_mismatch($sformatf("payload_byte %02h, expected %02h",
                                   rsp_payload_byte, want.data));
      end
      if (rsp_last_byte !== want.last) begin
         report_mismatch($sformatf("last_byte %0b, expected %0b", rsp_last_byte, want.last));
      end
      if (rsp_crc_error_total !== want.err_total) begin
         report_mismatch($sformatf("crc_error_total %0d, expected %0d",
                                   rsp_crc_error_total, want.err_total));
      end
      beats_checked++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         window_q.delete();
         beats_due.delete();
         crc_miss_total = '0;
         mismatch_count = 0;
         bytes_taken    = 0;
         frames_found   = 0;
         crc_misses     = 0;
         beats_checked  = 0;
         beats_pending <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            predict_byte(req_rx_byte);
         end
         if (rsp_valid && !rsp_stall) begin
            check_beat();
         end
         beats_pending <= beats_due.size();
      end
   end

endmodule

/* test/crc8_sliding_frame_finder_top_tb.sv */
// Testbench top for the CRC-8 frame finder: clock, reset, paced byte stimulus, stalls, verdict.
`timescale 1ns / 100ps

module crc8_sliding_frame_finder_top_tb;
   import c8sff_pkg::*;
   import c8sff_tb_pkg::*;

   localparam int PAYLOAD_LEN   = PAYLOAD_BYTES_DEF;
   // Bytes sent over the whole run, the directed part included.
   localparam int TOTAL_BYTES   = 280;
   // A full CRC walk plus a full read-back, with margin, to catch stray beats at the end.
   localparam int SETTLE_CYCLES = 2 * PAYLOAD_LEN + 40;

   typedef enum logic [1:0] {
      STALL_NONE,
      STALL_RANDOM,
      STALL_PERIODIC,
      STALL_HEAVY
   } stall_style_type;

   typedef enum int {
      FILL_RANDOM,
      FILL_ZEROS,
      FILL_ONES,
      FILL_ALTERNATE,
      FILL_WALKING
   } payload_fill_type;

   logic        clock       = 1'b0;
   logic        reset       = 1'b1;
   logic        req_valid   = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_stall   = 1'b0;
   logic        rsp_kind;
   logic [7:0]  rsp_payload_byte;
   logic        rsp_last_byte;
   logic [31:0] rsp_crc_error_total;

   int mismatch_count;
   int beats_pending;
   int bytes_taken;
   int frames_found;
   int crc_misses;
   int beats_checked;

   stall_style_type stall_style       = STALL_NONE;
   int              style_cycles_left = 0;
   int              stall_phase       = 0;
   int              burst_left        = 0;
   int              bytes_sent        = 0;
   logic [7:0]      frame_payload [$];

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   crc8_sliding_frame_finder_top i_dut (.*);

   crc8_sliding_frame_finder_checker #(.PAYLOAD_LEN(PAYLOAD_LEN)) i_checker (.*);

   // The receiver switches to a random stall style whenever the current one runs out: no
   // stalls at all, light random stalls, a fixed periodic pattern, and heavy random stalls. This
   // puts stalls on the first, middle and last beat of payload runs, and on error beats.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (style_cycles_left == 0) begin
            stall_style       <= stall_style_type'($urandom_range(0, 3));
            style_cycles_left <= $urandom_range(30, 250);
         end else begin
            style_cycles_left <= style_cycles_left - 1;
         end
         stall_phase <= (stall_phase + 1) % 7;
         case (stall_style)
            STALL_NONE:     rsp_stall <= 1'b0;
            STALL_RANDOM:   rsp_stall <= ($urandom_range(0, 99) < 35);
            STALL_PERIODIC: rsp_stall <= (stall_phase < 3);
            default:        rsp_stall <= ($urandom_range(0, 99) < 80);
         endcase
      end
   end

   // An idle stretch on the input side. The byte lines carry junk while valid is low, which
   // the block must ignore.
   task automatic pause_sender(input int cycles);
      req_valid   <= 1'b0;
      req_rx_byte <= 8'($urandom);
      repeat (cycles) @(posedge clock);
   endtask

   // One input beat. The sender runs in bursts of random length; most bursts are short with
   // a gap ahead of them, but now and then a long burst goes through back to back.
   task automatic send_byte(input logic [7:0] value);
      if (burst_left == 0) begin
         pause_sender($urandom_range(1, 8));
         burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(60, 120)
                                                   : $urandom_range(1, 12);
      end
      burst_left--;
      req_valid   <= 1'b1;
      req_rx_byte <= value;
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   // Holds the input idle until the checker has no result left to wait for. The first edge
   // is always taken so that the count already includes the byte accepted last.
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      do @(posedge clock); while (beats_pending != 0);
   endtask

   task automatic send_noise(input int count);
      repeat (count) send_byte(8'($urandom));
   endtask

   function automatic void build_payload(input payload_fill_type fill);
      frame_payload.delete();
      for (int i = 0; i < PAYLOAD_LEN; i++) begin
         case (fill)
            FILL_ZEROS:     frame_payload.push_back(8'h00);
            FILL_ONES:      frame_payload.push_back(8'hFF);
            FILL_ALTERNATE: frame_payload.push_back(i[0] ? 8'hFF : 8'h00);
            FILL_WALKING:   frame_payload.push_back(8'h01 << (i % 8));
            default:        frame_payload.push_back(8'($urandom));
         endcase
      end
   endfunction

   // Sends the built payload and its check byte. A nonzero crc_flip spoils the check byte;
   // a nonzero hit_mask flips payload bits after the CRC was taken, as a line error would.
   task automatic send_frame(input logic [7:0] crc_flip, input int hit_pos,
                             input logic [7:0] hit_mask);
      logic [7:0] check;
      check = frame_crc8(frame_payload, PAYLOAD_LEN) ^ crc_flip;
      frame_payload[hit_pos] = frame_payload[hit_pos] ^ hit_mask;
      foreach (frame_payload[i]) begin
         send_byte(frame_payload[i]);
      end
      send_byte(check);
   endtask

   initial begin
      int  pick;
      int  random_goal;
      int  mid_mark;
      bit  drained_mid;
      drained_mid = 1'b0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed part. A good frame whose payload swings between 0x00 and 0xFF fills the
      // window from empty and must come out whole. Then an all-ones payload with a wrong
      // check byte gives a mismatch and leaves 31 bytes behind in the window.
      build_payload(FILL_ALTERNATE);
      send_frame(8'h00, 0, 8'h00);
      build_payload(FILL_ONES);
      send_frame(8'h01, 0, 8'h00);
      wait_for_drain();

      // Random part. Mostly well-formed frames with random content, so the finder keeps
      // having to resync across leftover bytes; the rest is spoiled frames and line noise.
      random_goal = TOTAL_BYTES;
      mid_mark    = (bytes_sent + random_goal) / 2;
      while (bytes_sent < random_goal) begin
         if (!drained_mid && bytes_sent >= mid_mark) begin
            wait_for_drain();
            drained_mid = 1'b1;
         end
         pick = $urandom_range(0, 99);
         if (pick < 60) begin
            if ($urandom_range(0, 3) == 0) begin
               send_noise($urandom_range(1, 3));
            end
            build_payload(FILL_RANDOM);
            send_frame(8'h00, 0, 8'h00);
         end else if (pick < 72) begin
            build_payload(FILL_RANDOM);
            send_frame(8'($urandom_range(1, 255)), 0, 8'h00);
         end else if (pick < 82) begin
            build_payload(FILL_RANDOM);
            send_frame(8'h00, $urandom_range(0, PAYLOAD_LEN - 1),
                       8'(8'h01 << $urandom_range(0, 7)));
         end else if (pick < 92) begin
            send_noise($urandom_range(1, 20));
         end else begin
            build_payload(payload_fill_type'($urandom_range(int'(FILL_ZEROS),
                                                            int'(FILL_WALKING))));
            send_frame(8'h00, 0, 8'h00);
         end
      end

      wait_for_drain();
      repeat (SETTLE_CYCLES) @(posedge clock);

      $display("Covered %0d received bytes: %0d frames found, %0d CRC mismatches,",
               bytes_taken, frames_found, crc_misses);
      $display("and %0d result beats compared under mixed input gaps and output stalls.",
               beats_checked);
      if (mismatch_count == 0 && beats_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   // Watchdog, far beyond the slowest correct run.
   initial begin
      #4_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
